// ===== src/c1d_pkg.sv =====
// shared constants, codes and types for the 1-d convolution engine
package c1d_pkg;
    localparam int MAX_KERNEL  = 7;
    localparam int MAX_IN_CH   = 32;
    localparam int MAX_OUT_CH  = 32;
    localparam int MAX_SEQ_LEN = 256;
    localparam int W_DEPTH     = MAX_KERNEL * MAX_IN_CH * MAX_OUT_CH;
    localparam int WIN_DEPTH   = MAX_KERNEL * MAX_IN_CH;
    localparam int W_AW        = $clog2(W_DEPTH);
    localparam int WIN_AW      = $clog2(WIN_DEPTH);
    localparam int B_AW        = $clog2(MAX_OUT_CH);
    localparam int ACC_W       = 40;

    localparam logic [1:0] FUNC_WEIGHT = 2'd0;
    localparam logic [1:0] FUNC_BIAS   = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE = 2'd2;
    localparam logic [1:0] FUNC_FLUSH  = 2'd3;

    localparam logic [2:0] CFG_KERNEL_LEN   = 3'd0;
    localparam logic [2:0] CFG_SEQ_LEN      = 3'd1;
    localparam logic [2:0] CFG_IN_CHANNELS  = 3'd2;
    localparam logic [2:0] CFG_OUT_CHANNELS = 3'd3;
    localparam logic [2:0] CFG_RELU_ON      = 3'd4;

    typedef struct packed {
        logic bias_rd;
        logic mac_rd;
        logic relu;
    } t_mac_ctl;
endpackage

// ===== src/c1d_in_if.sv =====
// request channel carrying input items
interface c1d_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [12:0] addr;
    logic signed [15:0] value;
    logic        seq_start;
    modport source (output valid, func, addr, value, seq_start, input ready);
    modport sink (input valid, func, addr, value, seq_start, output ready);
endinterface

// ===== src/c1d_out_if.sv =====
// request channel carrying result items
interface c1d_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  time_index;
    logic [4:0]  out_channel;
    logic signed [15:0] out_value;
    logic        saturated;
    logic        last;
    modport source (output valid, time_index, out_channel, out_value, saturated, last,
                    input ready);
    modport sink (input valid, time_index, out_channel, out_value, saturated, last,
                  output ready);
endinterface

// ===== src/conv1d_same_relu_engine_top.sv =====
// top level: streaming 1-d convolution, same padding, bias and optional relu
// weight, bias and non-emitting sample or flush requests complete on acceptance
// a step-completing request runs its output step through the single shared
// multiply-accumulate, which reads the weight and window memories
// result for each output channel enters an output register; input is refused during a step
// reset (synchronous, active low) clears counters and restores register defaults; the
// weight, bias and window memories stay undefined until written
module conv1d_same_relu_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [8:0]  i_cfg_data,
    c1d_in_if.sink      in_ch,
    c1d_out_if.source   out_ch
);
    import c1d_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BIAS  = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // configuration registers
    logic [2:0] r_k;
    logic [8:0] r_seq;
    logic [5:0] r_cin, r_cout;
    logic       r_relu;

    // effective (clamped) configuration
    logic [2:0] eff_k, pad, hi;
    logic [8:0] eff_t;
    logic [5:0] eff_cin, eff_cout;

    always_comb begin
        eff_k    = (r_k == 3'd0) ? 3'd1 : r_k;
        eff_t    = (r_seq == 9'd0) ? 9'd1 : ((r_seq > 9'(MAX_SEQ_LEN)) ? 9'(MAX_SEQ_LEN) : r_seq);
        eff_cin  = (r_cin == 6'd0) ? 6'd1 : ((r_cin > 6'(MAX_IN_CH)) ? 6'(MAX_IN_CH) : r_cin);
        eff_cout = (r_cout == 6'd0) ? 6'd1
                 : ((r_cout > 6'(MAX_OUT_CH)) ? 6'(MAX_OUT_CH) : r_cout);
        pad      = (eff_k - 3'd1) >> 1;
        hi       = eff_k - 3'd1 - pad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= 3'd7;
            r_seq  <= 9'd252;
            r_cin  <= 6'd1;
            r_cout <= 6'd16;
            r_relu <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KERNEL_LEN:   r_k    <= i_cfg_data[2:0];
                CFG_SEQ_LEN:      r_seq  <= i_cfg_data;
                CFG_IN_CHANNELS:  r_cin  <= i_cfg_data[5:0];
                CFG_OUT_CHANNELS: r_cout <= i_cfg_data[5:0];
                CFG_RELU_ON:      r_relu <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequence counters and the ring slots that track them modulo the kernel depth
    logic [2:0] r_state, n_state;
    logic [8:0] r_in_t, n_in_t, r_nt, n_nt;
    logic [5:0] r_in_c, n_in_c;
    logic [2:0] r_in_slot, n_in_slot, r_nt_slot, n_nt_slot;

    // per-step sequencing
    logic [4:0]  r_o, n_o;
    logic [2:0]  r_kk, n_kk;
    logic [4:0]  r_c, n_c;
    logic [2:0]  r_slot, n_slot;
    logic signed [10:0] r_ti, n_ti;
    logic [W_AW-1:0] r_widx, n_widx;

    // output register
    logic        r_out_v, n_out_v;
    logic [7:0]  r_out_t;
    logic [4:0]  r_out_o;
    logic signed [15:0] r_out_val;
    logic        r_out_sat, r_out_last;
    logic        out_free, out_load;

    // memory ports
    logic            w_we, win_we, b_we;
    logic [WIN_AW-1:0] win_waddr;
    logic [15:0]     w_rdata, win_rdata, b_rdata;
    t_mac_ctl        mac_ctl;
    logic            mac_busy, mac_sat;
    logic signed [15:0] mac_val;

    // sample bookkeeping after an optional sequence restart
    logic       acc_in, st;
    logic [8:0] t_cur, nt_cur;
    logic [5:0] c_cur, c_wr, c_nxt;
    logic [2:0] slot_cur, ntslot_cur;
    logic       tap_ok;

    assign acc_in   = in_ch.valid & in_ch.ready;
    assign in_ch.ready = (r_state == S_IDLE);
    assign out_free = ~r_out_v | out_ch.ready;

    function automatic logic [2:0] slot_inc(input logic [2:0] s);
        slot_inc = (s == 3'(MAX_KERNEL - 1)) ? 3'd0 : s + 3'd1;
    endfunction

    always_comb begin
        st         = (in_ch.func == FUNC_SAMPLE) & in_ch.seq_start;
        t_cur      = st ? 9'd0 : r_in_t;
        nt_cur     = st ? 9'd0 : r_nt;
        c_cur      = st ? 6'd0 : r_in_c;
        slot_cur   = st ? 3'd0 : r_in_slot;
        ntslot_cur = st ? 3'd0 : r_nt_slot;
        c_wr       = (c_cur >= eff_cin) ? 6'd0 : c_cur;
        c_nxt      = c_wr + 6'd1;
        tap_ok     = ~r_ti[10] && (r_ti < $signed({2'b00, eff_t}));
    end

    always_comb begin
        n_state   = r_state;
        n_in_t    = r_in_t;
        n_in_c    = r_in_c;
        n_nt      = r_nt;
        n_in_slot = r_in_slot;
        n_nt_slot = r_nt_slot;
        n_o       = r_o;
        n_kk      = r_kk;
        n_c       = r_c;
        n_slot    = r_slot;
        n_ti      = r_ti;
        n_widx    = r_widx;
        w_we      = 1'b0;
        b_we      = 1'b0;
        win_we    = 1'b0;
        win_waddr = {slot_cur, c_wr[4:0]};
        mac_ctl   = '{bias_rd: 1'b0, mac_rd: 1'b0, relu: r_relu};
        out_load  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    case (in_ch.func)
                        FUNC_WEIGHT: w_we = (in_ch.addr < 13'(W_DEPTH));
                        FUNC_BIAS:   b_we = (in_ch.addr < 13'(MAX_OUT_CH));
                        FUNC_SAMPLE: begin
                            n_in_t    = t_cur;
                            n_in_c    = c_cur;
                            n_nt      = nt_cur;
                            n_in_slot = slot_cur;
                            n_nt_slot = ntslot_cur;
                            if (t_cur < eff_t) begin
                                win_we = 1'b1;
                                if (c_nxt < eff_cin) begin
                                    n_in_c = c_nxt;
                                end else begin
                                    n_in_c    = 6'd0;
                                    n_in_t    = t_cur + 9'd1;
                                    n_in_slot = slot_inc(slot_cur);
                                    // output step whose window just became whole
                                    if (nt_cur < eff_t &&
                                        ({1'b0, nt_cur} + 10'(hi)) <= {1'b0, t_cur}) begin
                                        n_o     = 5'd0;
                                        n_state = S_BIAS;
                                    end
                                end
                            end
                        end
                        FUNC_FLUSH: begin
                            if (r_in_t >= eff_t && r_nt < eff_t) begin
                                n_o     = 5'd0;
                                n_state = S_BIAS;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_BIAS: begin
                // bias read, then start the tap walk at the leftmost padded tap
                mac_ctl.bias_rd = 1'b1;
                n_kk   = 3'd0;
                n_c    = 5'd0;
                n_ti   = $signed({2'b00, r_nt}) - $signed({8'd0, pad});
                n_slot = (r_nt_slot >= pad) ? r_nt_slot - pad
                       : r_nt_slot + 3'(MAX_KERNEL) - pad;
                n_widx = W_AW'(r_o);
                n_state = S_MAC;
            end
            S_MAC: begin
                // one product per cycle; taps outside the sequence issue a bubble
                mac_ctl.mac_rd = tap_ok;
                n_widx = r_widx + W_AW'(eff_cout);
                if ({1'b0, r_c} == eff_cin - 6'd1) begin
                    n_c = 5'd0;
                    if (r_kk == eff_k - 3'd1) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_kk   = r_kk + 3'd1;
                        n_ti   = r_ti + 11'sd1;
                        n_slot = slot_inc(r_slot);
                    end
                end else begin
                    n_c = r_c + 5'd1;
                end
            end
            S_DRAIN: begin
                if (!mac_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if ({1'b0, r_o} == eff_cout - 6'd1) begin
                        n_nt      = r_nt + 9'd1;
                        n_nt_slot = slot_inc(r_nt_slot);
                        n_state   = S_IDLE;
                    end else begin
                        n_o     = r_o + 5'd1;
                        n_state = S_BIAS;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_v = out_load | (r_out_v & ~out_ch.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_t    <= 9'd0;
            r_in_c    <= 6'd0;
            r_nt      <= 9'd0;
            r_in_slot <= 3'd0;
            r_nt_slot <= 3'd0;
            r_out_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_in_t    <= n_in_t;
            r_in_c    <= n_in_c;
            r_nt      <= n_nt;
            r_in_slot <= n_in_slot;
            r_nt_slot <= n_nt_slot;
            r_out_v   <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o    <= n_o;
        r_kk   <= n_kk;
        r_c    <= n_c;
        r_slot <= n_slot;
        r_ti   <= n_ti;
        r_widx <= n_widx;
        if (out_load) begin
            r_out_t    <= r_nt[7:0];
            r_out_o    <= r_o;
            r_out_val  <= mac_val;
            r_out_sat  <= mac_sat;
            r_out_last <= ({1'b0, r_o} == eff_cout - 6'd1);
        end
    end

    assign out_ch.valid       = r_out_v;
    assign out_ch.time_index  = r_out_t;
    assign out_ch.out_channel = r_out_o;
    assign out_ch.out_value   = r_out_val;
    assign out_ch.saturated   = r_out_sat;
    assign out_ch.last        = r_out_last;

    // weight store, bias store and the window ring
    c1d_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (in_ch.addr[W_AW-1:0]),
        .i_wdata (in_ch.value),
        .i_raddr (r_widx),
        .o_rdata (w_rdata)
    );

    c1d_ram #(.WIDTH(16), .DEPTH(MAX_OUT_CH)) u_bram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (in_ch.addr[B_AW-1:0]),
        .i_wdata (in_ch.value),
        .i_raddr (r_o),
        .o_rdata (b_rdata)
    );

    c1d_ram #(.WIDTH(16), .DEPTH(WIN_DEPTH)) u_winram (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (win_waddr),
        .i_wdata (in_ch.value),
        .i_raddr ({r_slot, r_c}),
        .o_rdata (win_rdata)
    );

    c1d_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_bias   (b_rdata),
        .i_weight (w_rdata),
        .i_sample (win_rdata),
        .o_busy   (mac_busy),
        .o_value  (mac_val),
        .o_sat    (mac_sat)
    );
endmodule

// ===== src/c1d_ram.sv =====
// generic simple dual-port ram with registered read
module c1d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== src/c1d_mac.sv =====
// multiply-accumulate datapath with relu, rounding and saturation
module c1d_mac (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  c1d_pkg::t_mac_ctl      i_ctl,
    input  logic signed [15:0]     i_bias,
    input  logic signed [15:0]     i_weight,
    input  logic signed [15:0]     i_sample,
    output logic                   o_busy,
    output logic signed [15:0]     o_value,
    output logic                   o_sat
);
    import c1d_pkg::*;

    logic r_bias_d, r_mac_d, r_prod_v;
    logic signed [31:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] relu_acc;
    logic signed [ACC_W:0] rnd;
    logic signed [ACC_W-12:0] q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_d <= 1'b0;
            r_mac_d  <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_bias_d <= i_ctl.bias_rd;
            r_mac_d  <= i_ctl.mac_rd;
            r_prod_v <= r_mac_d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_weight * i_sample;
        if (r_bias_d) begin
            r_acc <= {{(ACC_W-28){i_bias[15]}}, i_bias, 12'd0};
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_busy = r_mac_d | r_prod_v;

    always_comb begin
        relu_acc = (i_ctl.relu && r_acc[ACC_W-1]) ? '0 : r_acc;
        rnd      = {relu_acc[ACC_W-1], relu_acc} + (ACC_W+1)'(2048);
        q        = rnd[ACC_W:12];
        if (q > 32767) begin
            o_value = 16'sh7fff;
            o_sat   = 1'b1;
        end else if (q < -32768) begin
            o_value = -16'sh8000;
            o_sat   = 1'b1;
        end else begin
            o_value = q[15:0];
            o_sat   = 1'b0;
        end
    end
endmodule

// ===== tb/tb_conv1d_same_relu_engine_top.sv =====
// testbench for the streaming 1-d convolution engine: predicted results checked per channel
module tb_conv1d_same_relu_engine_top;
    import c1d_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int TOTAL_ITEMS = 480;
    // weights loaded up front; every setting used keeps its taps below this index
    localparam int W_FILL = 192;
    // samples per random sequence stay at or below this
    localparam int MAX_SEQ_SAMPLES = 96;

    // one predicted output channel of one time step
    typedef struct {
        logic [7:0]         time_index;
        logic [4:0]         out_channel;
        logic signed [15:0] out_value;
        logic               saturated;
        logic               last;
    } t_conv_result;

    // mirror of the engine: stores, counters and registers, plus the pending results
    class conv_scoreboard;
        logic signed [15:0] weights[W_DEPTH];
        logic signed [15:0] biases[MAX_OUT_CH];
        logic signed [15:0] window[WIN_DEPTH];
        int unsigned in_time, in_chan, out_time;
        int unsigned reg_k, reg_t, reg_cin, reg_cout, reg_relu;
        t_conv_result pending[$];
        int errors;
        int checked;

        function new();
            in_time = 0; in_chan = 0; out_time = 0;
            reg_k = 7; reg_t = 252; reg_cin = 1; reg_cout = 16; reg_relu = 1;
            errors = 0; checked = 0;
        endfunction

        function int unsigned clip(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void set_reg(logic [2:0] idx, logic [8:0] data);
            case (idx)
                CFG_KERNEL_LEN:   reg_k = data[2:0];
                CFG_SEQ_LEN:      reg_t = data;
                CFG_IN_CHANNELS:  reg_cin = data[5:0];
                CFG_OUT_CHANNELS: reg_cout = data[5:0];
                CFG_RELU_ON:      reg_relu = data[0];
                default: ;
            endcase
        endfunction

        // all output channels of one time step
        function void compute_step(int unsigned t);
            int unsigned k, tl, cin, cout, pad;
            int ti;
            longint acc, s, q;
            logic signed [39:0] acc40;
            t_conv_result r;
            k = clip(reg_k, MAX_KERNEL);
            tl = clip(reg_t, MAX_SEQ_LEN);
            cin = clip(reg_cin, MAX_IN_CH);
            cout = clip(reg_cout, MAX_OUT_CH);
            pad = (k - 1) / 2;
            for (int o = 0; o < cout; o++) begin
                acc = longint'(biases[o]) * 4096;
                for (int kk = 0; kk < k; kk++) begin
                    ti = int'(t) + kk - int'(pad);
                    if (ti < 0 || ti >= int'(tl)) continue;
                    for (int c = 0; c < cin; c++)
                        acc += longint'(weights[(kk * cin + c) * cout + o]) *
                               longint'(window[(ti % MAX_KERNEL) * MAX_IN_CH + c]);
                end
                acc40 = acc[39:0];
                s = acc40;
                if (reg_relu != 0 && s < 0) s = 0;
                q = (s + 2048) >>> 12;
                r.saturated = 1'b0;
                if (q > 32767) begin
                    q = 32767; r.saturated = 1'b1;
                end else if (q < -32768) begin
                    q = -32768; r.saturated = 1'b1;
                end
                r.time_index = t[7:0];
                r.out_channel = o[4:0];
                r.out_value = q[15:0];
                r.last = (o + 1 == cout);
                pending.push_back(r);
            end
        endfunction

        // accepted input request
        function void note_request(logic [1:0] func, logic [12:0] addr,
                                   logic signed [15:0] value, logic start);
            int unsigned tl, k, cin, hi, tc;
            tl = clip(reg_t, MAX_SEQ_LEN);
            k = clip(reg_k, MAX_KERNEL);
            cin = clip(reg_cin, MAX_IN_CH);
            hi = k - 1 - (k - 1) / 2;
            case (func)
                FUNC_WEIGHT: begin
                    if (addr < W_DEPTH) weights[addr] = value;
                end
                FUNC_BIAS: begin
                    if (addr < MAX_OUT_CH) biases[addr] = value;
                end
                FUNC_SAMPLE: begin
                    if (start) begin
                        in_time = 0; in_chan = 0; out_time = 0;
                    end
                    if (in_time < tl) begin
                        // channel count left over from a wider setting restarts
                        if (in_chan >= cin) in_chan = 0;
                        window[(in_time % MAX_KERNEL) * MAX_IN_CH + in_chan] = value;
                        in_chan++;
                        if (in_chan >= cin) begin
                            in_chan = 0;
                            tc = in_time;
                            in_time++;
                            if (out_time < tl && out_time + hi <= tc) begin
                                compute_step(out_time);
                                out_time++;
                            end
                        end
                    end
                end
                default: begin
                    if (in_time >= tl && out_time < tl) begin
                        compute_step(out_time);
                        out_time++;
                    end
                end
            endcase
        endfunction

        function void check_result(t_conv_result got, longint now);
            t_conv_result want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result t=%0d ch=%0d val=%0d sat=%0b last=%0b",
                         now, got.time_index, got.out_channel, got.out_value,
                         got.saturated, got.last);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.time_index !== want.time_index || got.out_channel !== want.out_channel ||
                got.out_value !== want.out_value || got.saturated !== want.saturated ||
                got.last !== want.last) begin
                errors++;
                $display("%0t: mismatch exp t=%0d ch=%0d val=%0d sat=%0b last=%0b", now,
                         want.time_index, want.out_channel, want.out_value,
                         want.saturated, want.last);
                $display("%0t:          act t=%0d ch=%0d val=%0d sat=%0b last=%0b", now,
                         got.time_index, got.out_channel, got.out_value,
                         got.saturated, got.last);
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [8:0] i_cfg_data;

    c1d_in_if  in_if();
    c1d_out_if out_if();

    conv1d_same_relu_engine_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_if),
        .out_ch     (out_if)
    );

    conv_scoreboard conv_sb;
    int  cycles;
    int  req_count;
    int  phase_count;
    bit  send_gaps;   // random gaps between requests
    bit  recv_stalls; // random stalls on the result side

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     conv_sb.pending.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stall per result, check at the accepting edge
    initial begin
        t_conv_result got;
        int stall;
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = recv_stalls ? $urandom_range(0, 11) : 0;
            @(negedge i_clk);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_if.valid && out_if.ready)) @(posedge i_clk);
            got.time_index = out_if.time_index;
            got.out_channel = out_if.out_channel;
            got.out_value = out_if.out_value;
            got.saturated = out_if.saturated;
            got.last = out_if.last;
            conv_sb.check_result(got, $time);
        end
    end

    // one request, held until accepted; valid stays high into a back-to-back request
    task automatic send_req(logic [1:0] func, logic [12:0] addr, logic signed [15:0] value,
                            logic start);
        int gap;
        gap = send_gaps ? $urandom_range(0, 11) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.func <= func;
        in_if.addr <= addr;
        in_if.value <= value;
        in_if.seq_start <= start;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        conv_sb.note_request(func, addr, value, start);
        req_count++;
    endtask

    // wait for all results, then let the output register settle
    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (conv_sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [8:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        conv_sb.set_reg(idx, data);
    endtask

    // all five registers, with random bits above each field but the sequence length
    task automatic configure(int k, int t, int cin, int cout, int relu);
        drain();
        cfg_write(CFG_KERNEL_LEN, {6'($urandom_range(0, 63)), 3'(k)});
        cfg_write(CFG_SEQ_LEN, 9'(t));
        cfg_write(CFG_IN_CHANNELS, {3'($urandom_range(0, 7)), 6'(cin)});
        cfg_write(CFG_OUT_CHANNELS, {3'($urandom_range(0, 7)), 6'(cout)});
        cfg_write(CFG_RELU_ON, {8'($urandom_range(0, 255)), 1'(relu)});
        phase_count++;
    endtask

    // mix of full-range, small and extreme values
    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1: return 16'($urandom);
            2, 3: return 16'($urandom_range(0, 512) - 256);
            4: return 16'sh7fff;
            default: return 16'sh8000;
        endcase
    endfunction

    // occasional noise: weight or bias rewrite, early flush, stray seq_start
    task automatic noise_req();
        int span;
        span = conv_sb.clip(conv_sb.reg_k, MAX_KERNEL) * conv_sb.clip(conv_sb.reg_cin, MAX_IN_CH)
             * conv_sb.clip(conv_sb.reg_cout, MAX_OUT_CH);
        case ($urandom_range(0, 3))
            0: send_req(FUNC_WEIGHT, ($urandom_range(0, 5) == 0) ? 13'($urandom)
                        : 13'($urandom_range(0, span - 1)), pick_value(), 1'($urandom));
            1: send_req(FUNC_BIAS, ($urandom_range(0, 5) == 0) ? 13'($urandom)
                        : 13'($urandom_range(0, 31)), pick_value(), 1'($urandom));
            default: send_req(FUNC_FLUSH, 13'($urandom), 16'($urandom), 1'($urandom));
        endcase
    endtask

    // one sequence: samples with noise, sometimes cut short or overrun, then flushes
    task automatic run_sequence();
        int n_samples, total, pad;
        n_samples = conv_sb.clip(conv_sb.reg_t, MAX_SEQ_LEN) *
                    conv_sb.clip(conv_sb.reg_cin, MAX_IN_CH);
        pad = (conv_sb.clip(conv_sb.reg_k, MAX_KERNEL) - 1) / 2;
        case ($urandom_range(0, 7))
            0: total = $urandom_range(1, n_samples);           // broken: cut short
            1: total = n_samples + $urandom_range(1, 4);       // overrun: ignored samples
            default: total = n_samples;
        endcase
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(0, 9) == 0) noise_req();
            send_req(FUNC_SAMPLE, 13'($urandom), pick_value(), i == 0);
        end
        for (int i = 0; i < pad + 2; i++)
            send_req(FUNC_FLUSH, 13'($urandom), 16'($urandom), 1'($urandom));
    endtask

    initial begin
        int k, t, cin, cout;
        conv_sb = new();
        cycles = 0;
        req_count = 0;
        phase_count = 0;
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.func = FUNC_WEIGHT;
        in_if.addr = '0;
        in_if.value = '0;
        in_if.seq_start = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill the weights every setting below can reach, and every bias
        for (int a = 0; a < W_FILL; a++)
            send_req(FUNC_WEIGHT, 13'(a), pick_value(), 1'b0);
        for (int a = 0; a < MAX_OUT_CH; a++)
            send_req(FUNC_BIAS, 13'(a), pick_value(), 1'b0);

        // directed: early flush, extremes, stray seq_start, ignored writes, overrun
        send_gaps = 1'b1;
        recv_stalls = 1'b1;
        configure(3, 3, 1, 2, 0);
        send_req(FUNC_FLUSH, 13'h1fff, 16'sh7fff, 1'b1);
        send_req(FUNC_WEIGHT, 13'h1fff, 16'sh7fff, 1'b0);
        send_req(FUNC_BIAS, 13'd40, 16'sh8000, 1'b1);
        send_req(FUNC_SAMPLE, 13'h0000, 16'sh7fff, 1'b1);
        send_req(FUNC_SAMPLE, 13'h1fff, 16'sh8000, 1'b0);
        send_req(FUNC_FLUSH, 13'h0000, 16'sh0000, 1'b0);
        send_req(FUNC_SAMPLE, 13'h0aaa, 16'sh0000, 1'b0);
        send_req(FUNC_SAMPLE, 13'h1555, 16'sh1234, 1'b0);
        for (int i = 0; i < 3; i++) send_req(FUNC_FLUSH, 13'h0, 16'sh0, i == 0);

        // zero registers count as one, relu off
        configure(0, 0, 0, 0, 0);
        send_req(FUNC_SAMPLE, 13'h0, 16'sh8000, 1'b1);
        send_req(FUNC_FLUSH, 13'h0, 16'sh0, 1'b0);

        // channel count left too high after the input width shrinks
        configure(5, 4, 3, 2, 1);
        send_req(FUNC_SAMPLE, 13'h0, 16'sh0100, 1'b1);
        send_req(FUNC_SAMPLE, 13'h0, 16'sh0200, 1'b0);
        configure(5, 4, 2, 2, 1);
        for (int i = 0; i < 8; i++) send_req(FUNC_SAMPLE, 13'h0, pick_value(), 1'b0);
        for (int i = 0; i < 4; i++) send_req(FUNC_FLUSH, 13'h0, 16'sh0, 1'b0);

        // registers above range saturate: input width, then output width
        configure(1, 3, 63, 2, 1);
        run_sequence();
        configure(3, 2, 1, 63, 0);
        run_sequence();

        // sequence length above range: a few samples, then a flush that comes too early
        configure(1, 300, 1, 1, 1);
        for (int i = 0; i < 4; i++) send_req(FUNC_SAMPLE, 13'h0, pick_value(), i == 0);
        send_req(FUNC_FLUSH, 13'h0, 16'sh0, 1'b0);

        // random settings, mostly small sizes; even kernels used as given
        while (req_count < TOTAL_ITEMS) begin
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
            do begin
                k = $urandom_range(0, 7);
                t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) % 40
                                                : $urandom_range(1, 10);
                cin = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 63)
                                                  : $urandom_range(0, 4);
                cout = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 63)
                                                   : $urandom_range(0, 6);
            end while (conv_sb.clip(k, MAX_KERNEL) * conv_sb.clip(cin, MAX_IN_CH) *
                       conv_sb.clip(cout, MAX_OUT_CH) > W_FILL ||
                       conv_sb.clip(t, MAX_SEQ_LEN) * conv_sb.clip(cin, MAX_IN_CH) >
                       MAX_SEQ_SAMPLES);
            configure(k, t, cin, cout, $urandom_range(0, 1));
            run_sequence();
        end

        drain();
        $display("covered %0d requests over %0d register settings, %0d results checked",
                 req_count, phase_count, conv_sb.checked);
        if (conv_sb.errors == 0 && conv_sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results never arrived", conv_sb.errors,
                     conv_sb.pending.size());
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
